[rtl/poc_pkg.sv]
// ----------------------------------------------------------------------------
// Picture order count package
// Shared constants, register indexes, status codes and command/status types.
// ----------------------------------------------------------------------------
package poc_pkg;

    localparam int CYCLE_DEPTH_DEFAULT = 256;

    // Register indexes
    localparam logic [2:0] REG_POC_TYPE   = 3'd0;
    localparam logic [2:0] REG_LOG2_LSB   = 3'd1;
    localparam logic [2:0] REG_LOG2_FRAME = 3'd2;
    localparam logic [2:0] REG_CYCLE_LEN  = 3'd3;
    localparam logic [2:0] REG_EXP_DELTA  = 3'd4;
    localparam logic [2:0] REG_NONREF_OFS = 3'd5;
    localparam logic [2:0] REG_T2B_OFS    = 3'd6;

    // Status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_PRED = 2'd1;
    localparam logic [1:0] STATUS_BAD_TYPE = 2'd2;

    // Operations
    localparam logic OP_DECODE = 1'b0;
    localparam logic OP_TABLE  = 1'b1;

    // POC methods
    localparam logic [1:0] POC_TYPE_0 = 2'd0;
    localparam logic [1:0] POC_TYPE_1 = 2'd1;
    localparam logic [1:0] POC_TYPE_2 = 2'd2;
    localparam logic [1:0] POC_TYPE_3 = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture the request and compute the frame offset
        logic div_start;  // clear divider
        logic div_step;   // one restoring division step
        logic mul_step;   // cycle count times expected delta
        logic sum_start;  // start table accumulation
        logic sum_step;   // add one table entry
        logic finish;     // form counts and update state
    } poc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_sum;   // method 1 with a positive absolute frame number
        logic sum_done;   // last table entry added
    } poc_stat_t;

    // Saturate a log2 setting to 4..16
    function automatic logic [4:0] clamp_log2(input logic [4:0] v);
        logic [4:0] r;
        begin
            r = v;
            if (v < 5'd4) r = 5'd4;
            else if (v > 5'd16) r = 5'd16;
            return r;
        end
    endfunction

endpackage

[rtl/poc_ctrl.sv]
// ----------------------------------------------------------------------------
// Picture order count controller
// Sequences load, division, multiply, table sum and finish for one request.
// ----------------------------------------------------------------------------
module poc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_busy,
    input  poc_pkg::poc_stat_t stat,
    output poc_pkg::poc_cmd_t  cmd,
    output logic              idle
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (stat.need_sum)
                begin
                    cmd.div_start = 1'b1;
                    cnt_next      = 6'd0;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31) state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_step  = 1'b1;
                cmd.sum_start = 1'b1;
                state_next    = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (stat.sum_done) state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign idle = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    // A new request is only taken while idle.
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == ST_IDLE)
        else $error("load outside idle");
    // The division runs exactly 32 steps before the multiply.
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_step |-> $past(cnt_reg) == 6'd31)
        else $error("short division");
    // Finish never happens while the output still holds a result.
    a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !out_busy)
        else $error("finish overwrote result");
`endif

endmodule

[rtl/poc_dp.sv]
// ----------------------------------------------------------------------------
// Picture order count datapath
// Holds picture state, offset table, divider, multiplier and accumulator.
// ----------------------------------------------------------------------------
module poc_dp #(
    parameter int CYCLE_DEPTH = poc_pkg::CYCLE_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  poc_pkg::poc_cmd_t  cmd,
    output poc_pkg::poc_stat_t stat,
    input  logic [171:0]      req,
    input  logic [1:0]        poc_type,
    input  logic [4:0]        log2_max_poc_lsb,
    input  logic [4:0]        log2_max_frame_num,
    input  logic [7:0]        cycle_length,
    input  logic [31:0]       expected_cycle_delta,
    input  logic [31:0]       non_ref_offset,
    input  logic [31:0]       top_to_bottom_offset,
    output logic [97:0]       result
);

    localparam int IW = (CYCLE_DEPTH > 1) ? $clog2(CYCLE_DEPTH) : 1;

    // Captured request
    logic        op_reg, idr_reg, isref_reg, mmco5_reg;
    logic [15:0] lsb_reg, frame_reg;
    logic [31:0] dbot_reg, dfirst_reg, dsecond_reg;
    logic [1:0]  status_reg;
    logic [31:0] fno_reg, absf_reg;

    // Picture state
    logic        ref_valid_reg, ref_mmco5_reg, prev_valid_reg, prev_mmco5_reg;
    logic [31:0] ref_msb_reg, ref_top_reg, prev_offset_reg;
    logic [15:0] ref_lsb_reg, prev_frame_reg;

    // Arithmetic
    logic [31:0] quot_reg, rem_reg, dividend_reg;
    logic [31:0] acc_reg;
    logic [8:0]  idx_reg;
    logic [7:0]  pos_reg;
    logic [31:0] mem [CYCLE_DEPTH];
    logic [31:0] rd_reg;
    logic        rd_ok_reg;

    // Field extraction
    logic        in_op, in_idr, in_isref, in_mmco5;
    logic [15:0] in_lsb, in_frame;
    logic [7:0]  in_eidx;
    logic [31:0] in_eval;
    logic [15:0] lsb_mask, frame_mask;
    logic [16:0] max_lsb, max_frame;

    assign in_op    = req[0];
    assign in_idr   = req[33];
    assign in_isref = req[34];
    assign in_mmco5 = req[35];
    assign in_eidx  = req[139:132];
    assign in_eval  = req[171:140];
    assign max_lsb    = 17'd1 << poc_pkg::clamp_log2(log2_max_poc_lsb);
    assign max_frame  = 17'd1 << poc_pkg::clamp_log2(log2_max_frame_num);
    assign lsb_mask   = 16'(max_lsb - 17'd1);
    assign frame_mask = 16'(max_frame - 17'd1);
    assign in_lsb   = req[16:1] & lsb_mask;
    assign in_frame = req[32:17] & frame_mask;

    // Status and frame number offset at load
    logic [1:0]  ld_status;
    logic [31:0] ld_fno, ld_absf, prev_off;
    always_comb
    begin
        ld_status = poc_pkg::STATUS_OK;
        if (in_op == poc_pkg::OP_TABLE) ld_status = poc_pkg::STATUS_OK;
        else if (poc_type == poc_pkg::POC_TYPE_3) ld_status = poc_pkg::STATUS_BAD_TYPE;
        else if (!in_idr && ((poc_type == poc_pkg::POC_TYPE_0) ? !ref_valid_reg
                                                                : !prev_valid_reg))
            ld_status = poc_pkg::STATUS_NO_PRED;
        prev_off = (in_idr || prev_mmco5_reg) ? 32'd0 : prev_offset_reg;
        if (in_idr || poc_type == poc_pkg::POC_TYPE_0) ld_fno = 32'd0;
        else if (prev_frame_reg > in_frame) ld_fno = prev_off + {15'd0, max_frame};
        else ld_fno = prev_off;
        ld_absf = (cycle_length != 8'd0) ? ld_fno + {16'd0, in_frame} : 32'd0;
        if (!in_isref && $signed(ld_absf) > 0) ld_absf = ld_absf - 32'd1;
    end

    assign stat.need_sum = !op_reg && status_reg == poc_pkg::STATUS_OK &&
                           poc_type == poc_pkg::POC_TYPE_1 &&
                           $signed(absf_reg) > 0 && cycle_length != 8'd0;
    assign stat.sum_done = rd_ok_reg && ({1'b0, pos_reg} + 9'd1 == idx_reg);

    // Divider: (absf - 1) by cycle_length, one bit per step
    logic [32:0] trial;
    assign trial = {rem_reg, dividend_reg[31]} - {25'd0, cycle_length};

    // Table read index
    logic [IW-1:0] rd_idx;
    logic          rd_in;
    assign rd_idx = IW'(idx_reg);
    assign rd_in  = idx_reg < 9'(CYCLE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= in_op;
            idr_reg     <= in_idr;
            isref_reg   <= in_isref;
            mmco5_reg   <= in_mmco5;
            lsb_reg     <= in_lsb;
            frame_reg   <= in_frame;
            dbot_reg    <= req[67:36];
            dfirst_reg  <= req[99:68];
            dsecond_reg <= req[131:100];
            status_reg  <= ld_status;
            fno_reg     <= ld_fno;
            absf_reg    <= ld_absf;
            if (in_op == poc_pkg::OP_TABLE && 9'(in_eidx) < 9'(CYCLE_DEPTH))
                mem[IW'(in_eidx)] <= in_eval;
        end
        if (cmd.div_start)
        begin
            dividend_reg <= absf_reg - 32'd1;
            rem_reg      <= 32'd0;
            quot_reg     <= 32'd0;
        end
        if (cmd.div_step)
        begin
            dividend_reg <= {dividend_reg[30:0], 1'b0};
            if (!trial[32])
            begin
                rem_reg  <= trial[31:0];
                quot_reg <= {quot_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= {rem_reg[30:0], dividend_reg[31]};
                quot_reg <= {quot_reg[30:0], 1'b0};
            end
        end
        if (cmd.mul_step)
        begin
            acc_reg <= quot_reg * expected_cycle_delta;
            pos_reg <= rem_reg[7:0];
        end
        if (cmd.sum_start)
        begin
            idx_reg   <= 9'd0;
            rd_ok_reg <= 1'b0;
        end
        if (cmd.sum_step)
        begin
            rd_reg    <= rd_in ? mem[rd_idx] : 32'd0;
            rd_ok_reg <= 1'b1;
            idx_reg   <= idx_reg + 9'd1;
            if (rd_ok_reg) acc_reg <= acc_reg + rd_reg;
        end
    end

    // Final counts
    logic [31:0] half, prev_l, prev_m, msb, top, bot, t2, expected;
    logic        lsb_lt, lsb_gt;
    logic [32:0] cur_e, prev_e;
    always_comb
    begin
        half   = {16'd0, max_lsb[16:1]};
        prev_l = 32'd0;
        prev_m = 32'd0;
        if (!idr_reg)
        begin
            if (ref_mmco5_reg) prev_l = ref_top_reg;
            else
            begin
                prev_m = ref_msb_reg;
                prev_l = {16'd0, ref_lsb_reg};
            end
        end
        cur_e  = {17'd0, lsb_reg};
        prev_e = {prev_l[31], prev_l};
        lsb_lt = $signed(cur_e) < $signed(prev_e);
        lsb_gt = $signed(cur_e) > $signed(prev_e);
        if (lsb_lt && $signed(prev_e - cur_e) >= $signed({1'b0, half}))
            msb = prev_m + {15'd0, max_lsb};
        else if (lsb_gt && $signed(cur_e - prev_e) > $signed({1'b0, half}))
            msb = prev_m - {15'd0, max_lsb};
        else
            msb = prev_m;
        expected = stat.need_sum ? acc_reg : 32'd0;
        if (!isref_reg) expected = expected + non_ref_offset;
        t2 = (fno_reg + {16'd0, frame_reg}) << 1;
        if (idr_reg) t2 = 32'd0;
        else if (!isref_reg) t2 = t2 - 32'd1;
        top = 32'd0;
        bot = 32'd0;
        if (!op_reg && status_reg == poc_pkg::STATUS_OK)
        begin
            unique case (poc_type)
                poc_pkg::POC_TYPE_0:
                begin
                    top = msb + {16'd0, lsb_reg};
                    bot = top + dbot_reg;
                end
                poc_pkg::POC_TYPE_1:
                begin
                    top = expected + dfirst_reg;
                    bot = top + top_to_bottom_offset + dsecond_reg;
                end
                default:
                begin
                    top = t2;
                    bot = t2;
                end
            endcase
        end
        if (op_reg || status_reg != poc_pkg::STATUS_OK) msb = 32'd0;
    end

    assign result = {($signed(top) <= $signed(bot)) ? top : bot, bot, top, status_reg};

    // State update on finish
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_valid_reg   <= 1'b0;
            ref_mmco5_reg   <= 1'b0;
            ref_msb_reg     <= '0;
            ref_lsb_reg     <= '0;
            ref_top_reg     <= '0;
            prev_valid_reg  <= 1'b0;
            prev_mmco5_reg  <= 1'b0;
            prev_frame_reg  <= '0;
            prev_offset_reg <= '0;
        end
        else if (cmd.finish && !op_reg && status_reg == poc_pkg::STATUS_OK)
        begin
            prev_valid_reg  <= 1'b1;
            prev_frame_reg  <= frame_reg;
            prev_offset_reg <= fno_reg;
            prev_mmco5_reg  <= mmco5_reg;
            if (isref_reg)
            begin
                ref_valid_reg <= 1'b1;
                ref_msb_reg   <= (poc_type == poc_pkg::POC_TYPE_0) ? msb : 32'd0;
                ref_lsb_reg   <= lsb_reg;
                ref_top_reg   <= top;
                ref_mmco5_reg <= mmco5_reg;
            end
        end
    end

`ifndef SYNTHESIS
    // Reference state never becomes valid without a previous picture.
    a_ref_prev: assert property (@(posedge clk) disable iff (!rst_n)
        ref_valid_reg |-> prev_valid_reg)
        else $error("reference without previous picture");
    // Error results carry zero counts.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && status_reg != poc_pkg::STATUS_OK |-> top == 32'd0 && bot == 32'd0)
        else $error("nonzero count on error");
    // The summed position never passes the table.
    a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sum_step |-> idx_reg <= 9'd256)
        else $error("table index overrun");
`endif

endmodule

[rtl/picture_order_count_decoder.sv]
// A request is captured on acceptance and its result registered at the finish. Table
// writes, methods 0 and 2 and error results go from load straight to finish; method 1
// with a positive absolute frame number first runs division, multiply and table sum.
// A stalled result delays the finish. Requests are handled one at a time; for method 1
// the divider runs 32 steps and the table sum adds one entry per cycle. The output
// register frees the input side.
// Reset: asynchronous active low; registers to their defaults, no picture history.
// ----------------------------------------------------------------------------
// Picture order count decoder
// Top level with stream ports, APB register file, controller and datapath.
// ----------------------------------------------------------------------------
module picture_order_count_decoder #(
    parameter int CYCLE_DEPTH = poc_pkg::CYCLE_DEPTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation, poc_lsb, frame_number, is_idr, is_reference, has_mmco5,
    // delta_bottom, delta_first, delta_second, entry_index, entry_value
    input  logic [175:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, top_count, bottom_count, picture_count
    output logic [103:0] m_tdata
);

    logic [1:0]  poc_type_reg;
    logic [4:0]  log2_lsb_reg, log2_frame_reg;
    logic [7:0]  cycle_len_reg;
    logic [31:0] exp_delta_reg, nonref_reg, t2b_reg;
    logic [2:0]  widx;

    assign pready = 1'b1;
    assign widx   = paddr[4:2];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poc_type_reg   <= 2'd0;
            log2_lsb_reg   <= 5'd4;
            log2_frame_reg <= 5'd4;
            cycle_len_reg  <= '0;
            exp_delta_reg  <= '0;
            nonref_reg     <= '0;
            t2b_reg        <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (widx)
                poc_pkg::REG_POC_TYPE:   poc_type_reg   <= pwdata[1:0];
                poc_pkg::REG_LOG2_LSB:   log2_lsb_reg   <= pwdata[4:0];
                poc_pkg::REG_LOG2_FRAME: log2_frame_reg <= pwdata[4:0];
                poc_pkg::REG_CYCLE_LEN:  cycle_len_reg  <= pwdata[7:0];
                poc_pkg::REG_EXP_DELTA:  exp_delta_reg  <= pwdata;
                poc_pkg::REG_NONREF_OFS: nonref_reg     <= pwdata;
                poc_pkg::REG_T2B_OFS:    t2b_reg        <= pwdata;
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        unique case (widx)
            poc_pkg::REG_POC_TYPE:   prdata = {30'd0, poc_type_reg};
            poc_pkg::REG_LOG2_LSB:   prdata = {27'd0, log2_lsb_reg};
            poc_pkg::REG_LOG2_FRAME: prdata = {27'd0, log2_frame_reg};
            poc_pkg::REG_CYCLE_LEN:  prdata = {24'd0, cycle_len_reg};
            poc_pkg::REG_EXP_DELTA:  prdata = exp_delta_reg;
            poc_pkg::REG_NONREF_OFS: prdata = nonref_reg;
            poc_pkg::REG_T2B_OFS:    prdata = t2b_reg;
            default:                 prdata = 32'd0;
        endcase
    end

    poc_pkg::poc_cmd_t  cmd;
    poc_pkg::poc_stat_t stat;
    logic               idle, in_fire;
    logic [97:0]        result;
    logic [103:0]       out_reg;
    logic               out_valid_reg;

    assign s_tready = idle;
    assign in_fire  = s_tvalid && s_tready;

    poc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_busy (out_valid_reg && !m_tready),
        .stat     (stat),
        .cmd      (cmd),
        .idle     (idle)
    );

    poc_dp #(.CYCLE_DEPTH(CYCLE_DEPTH)) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .stat                 (stat),
        .req                  (s_tdata[171:0]),
        .poc_type             (poc_type_reg),
        .log2_max_poc_lsb     (log2_lsb_reg),
        .log2_max_frame_num   (log2_frame_reg),
        .cycle_length         (cycle_len_reg),
        .expected_cycle_delta (exp_delta_reg),
        .non_ref_offset       (nonref_reg),
        .top_to_bottom_offset (t2b_reg),
        .result               (result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish) out_reg <= {6'd0, result};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Picture order count decoder testbench
// Drives slice-header requests and table writes into the decoder through
// its stream port, reprograms the POC method over APB between phases, and
// compares every result against a predictor that tracks the same picture
// history, register settings and cycle offset table.
// ----------------------------------------------------------------------------
module tb;

    localparam int TIMEOUT_CYCLES = 600000;
    localparam int IDLE_PCT       = 29;

    // One input request, unpacked.
    typedef struct {
        logic        op;
        logic [15:0] poc_lsb;
        logic [15:0] frame_number;
        logic        is_idr;
        logic        is_reference;
        logic        has_mmco5;
        logic [31:0] delta_bottom;
        logic [31:0] delta_first;
        logic [31:0] delta_second;
        logic [7:0]  entry_index;
        logic [31:0] entry_value;
    } poc_req_t;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] top;
        logic [31:0] bottom;
        logic [31:0] frame_poc;
    } poc_res_t;

    // Predicts the counts of each picture and holds the pending results.
    class poc_scoreboard;
        logic [1:0]  poc_type;
        logic [4:0]  log2_lsb;
        logic [4:0]  log2_frame;
        logic [7:0]  cycle_len;
        logic [31:0] exp_delta;
        logic [31:0] nonref_ofs;
        logic [31:0] t2b_ofs;
        bit          have_ref;
        logic [31:0] ref_msb_q;
        logic [15:0] ref_lsb_q;
        logic [31:0] ref_top_q;
        bit          ref_mmco5_q;
        bit          have_prev;
        logic [15:0] prev_frame_q;
        logic [31:0] prev_ofs_q;
        bit          prev_mmco5_q;
        logic [31:0] offsets[256];
        bit          written[256];
        poc_res_t    pending[$];
        int          errors;
        int          checked;
        int          table_writes;
        int          status_seen[3];

        function new();
            poc_type = poc_pkg::POC_TYPE_0;
            log2_lsb = 5'd4;
            log2_frame = 5'd4;
            cycle_len = '0;
            exp_delta = '0;
            nonref_ofs = '0;
            t2b_ofs = '0;
            have_ref = 0;
            ref_msb_q = '0;
            ref_lsb_q = '0;
            ref_top_q = '0;
            ref_mmco5_q = 0;
            have_prev = 0;
            prev_frame_q = '0;
            prev_ofs_q = '0;
            prev_mmco5_q = 0;
            errors = 0;
            checked = 0;
            table_writes = 0;
            foreach (written[i]) written[i] = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void set_reg(int idx, logic [31:0] v);
            case (idx)
                poc_pkg::REG_POC_TYPE:   poc_type = v[1:0];
                poc_pkg::REG_LOG2_LSB:   log2_lsb = v[4:0];
                poc_pkg::REG_LOG2_FRAME: log2_frame = v[4:0];
                poc_pkg::REG_CYCLE_LEN:  cycle_len = v[7:0];
                poc_pkg::REG_EXP_DELTA:  exp_delta = v;
                poc_pkg::REG_NONREF_OFS: nonref_ofs = v;
                poc_pkg::REG_T2B_OFS:    t2b_ofs = v;
                default: ;
            endcase
        endfunction

        function int sat_log2(logic [4:0] v);
            if (v < 5'd4) return 4;
            if (v > 5'd16) return 16;
            return int'(v);
        endfunction

        // Works out the result of one accepted request and updates history.
        function void note(poc_req_t r);
            logic [31:0] max_lsb, max_frame, lsb, frame, msb, fno, top, bot, prev_m;
            logic [31:0] expd, prev_off, t;
            longint      prev_l, cur, half, absf, cnt, pos;
            logic [1:0]  st;
            poc_res_t    res;
            max_lsb = 32'd1 << sat_log2(log2_lsb);
            max_frame = 32'd1 << sat_log2(log2_frame);
            lsb = {16'd0, r.poc_lsb} & (max_lsb - 1);
            frame = {16'd0, r.frame_number} & (max_frame - 1);
            st = poc_pkg::STATUS_OK;
            top = '0;
            bot = '0;
            msb = '0;
            fno = '0;
            if (r.op == poc_pkg::OP_TABLE)
            begin
                offsets[r.entry_index] = r.entry_value;
                written[r.entry_index] = 1;
                table_writes++;
            end
            else if (poc_type == poc_pkg::POC_TYPE_3)
            begin
                st = poc_pkg::STATUS_BAD_TYPE;
            end
            else if (!r.is_idr && (poc_type == poc_pkg::POC_TYPE_0 ? !have_ref : !have_prev))
            begin
                st = poc_pkg::STATUS_NO_PRED;
            end
            else if (poc_type == poc_pkg::POC_TYPE_0)
            begin
                prev_l = 0;
                prev_m = '0;
                cur = longint'(lsb);
                half = longint'(max_lsb >> 1);
                if (!r.is_idr)
                begin
                    if (ref_mmco5_q) prev_l = longint'(signed'(ref_top_q));
                    else
                    begin
                        prev_m = ref_msb_q;
                        prev_l = longint'(ref_lsb_q);
                    end
                end
                if (cur < prev_l && prev_l - cur >= half) msb = prev_m + max_lsb;
                else if (cur > prev_l && cur - prev_l > half) msb = prev_m - max_lsb;
                else msb = prev_m;
                top = msb + lsb;
                bot = top + r.delta_bottom;
            end
            else
            begin
                prev_off = (r.is_idr || prev_mmco5_q) ? 32'd0 : prev_ofs_q;
                if (r.is_idr) fno = '0;
                else if ({16'd0, prev_frame_q} > frame) fno = prev_off + max_frame;
                else fno = prev_off;
                if (poc_type == poc_pkg::POC_TYPE_1)
                begin
                    absf = 0;
                    expd = '0;
                    if (cycle_len != 0) absf = longint'(signed'(fno + frame));
                    if (!r.is_reference && absf > 0) absf = absf - 1;
                    if (absf > 0 && cycle_len != 0)
                    begin
                        cnt = (absf - 1) / longint'(cycle_len);
                        pos = (absf - 1) % longint'(cycle_len);
                        expd = cnt[31:0] * exp_delta;
                        for (int i = 0; i <= pos; i++) expd += offsets[i];
                    end
                    if (!r.is_reference) expd += nonref_ofs;
                    top = expd + r.delta_first;
                    bot = top + t2b_ofs + r.delta_second;
                end
                else
                begin
                    if (r.is_idr) t = '0;
                    else if (!r.is_reference) t = 2 * (fno + frame) - 1;
                    else t = 2 * (fno + frame);
                    top = t;
                    bot = t;
                end
            end
            if (r.op == poc_pkg::OP_DECODE && st == poc_pkg::STATUS_OK)
            begin
                have_prev = 1;
                prev_frame_q = frame[15:0];
                prev_ofs_q = fno;
                prev_mmco5_q = r.has_mmco5;
                if (r.is_reference)
                begin
                    have_ref = 1;
                    ref_msb_q = msb;
                    ref_lsb_q = lsb[15:0];
                    ref_top_q = top;
                    ref_mmco5_q = r.has_mmco5;
                end
            end
            res.status = st;
            res.top = top;
            res.bottom = bot;
            res.frame_poc = (signed'(top) <= signed'(bot)) ? top : bot;
            pending.push_back(res);
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        // Compares one accepted result with the oldest pending prediction.
        task check(logic [103:0] d);
            poc_res_t e;
            if (pending.size() == 0)
            begin
                report($sformatf("result with nothing pending, data %h", d));
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e.status <= poc_pkg::STATUS_BAD_TYPE) status_seen[e.status]++;
            if (d[1:0] !== e.status)
                report($sformatf("#%0d status %0d, expected %0d", checked, d[1:0], e.status));
            if (d[33:2] !== e.top)
                report($sformatf("#%0d top %0d, expected %0d", checked,
                                 signed'(d[33:2]), signed'(e.top)));
            if (d[65:34] !== e.bottom)
                report($sformatf("#%0d bottom %0d, expected %0d", checked,
                                 signed'(d[65:34]), signed'(e.bottom)));
            if (d[97:66] !== e.frame_poc)
                report($sformatf("#%0d frame poc %0d, expected %0d", checked,
                                 signed'(d[97:66]), signed'(e.frame_poc)));
        endtask
    endclass

    logic         clk = 1'b0;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    logic [175:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;

    poc_scoreboard sb;
    bit            quiet;
    int            cycles = 0;
    int            items_sent;
    logic [15:0]   next_frame;
    logic [15:0]   next_lsb;

    picture_order_count_decoder DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > TIMEOUT_CYCLES)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: check accepted results and stall at random.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) sb.check(m_tdata);
        if (!rst_n) m_tready <= 1'b0;
        else m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic logic [175:0] pack_req(poc_req_t r);
        logic [175:0] v;
        v = '0;
        v[0]       = r.op;
        v[16:1]    = r.poc_lsb;
        v[32:17]   = r.frame_number;
        v[33]      = r.is_idr;
        v[34]      = r.is_reference;
        v[35]      = r.has_mmco5;
        v[67:36]   = r.delta_bottom;
        v[99:68]   = r.delta_first;
        v[131:100] = r.delta_second;
        v[139:132] = r.entry_index;
        v[171:140] = r.entry_value;
        return v;
    endfunction

    task automatic apb_write(int idx, logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx * 4);
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    // Presents one request and holds it until it is accepted.
    task automatic send(poc_req_t r);
        if (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pack_req(r);
        do @(posedge clk); while (!s_tready);
        sb.note(r);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic poc_req_t blank_req();
        poc_req_t r;
        r.op = poc_pkg::OP_DECODE;
        r.poc_lsb = '0;
        r.frame_number = '0;
        r.is_idr = 1'b0;
        r.is_reference = 1'b1;
        r.has_mmco5 = 1'b0;
        r.delta_bottom = '0;
        r.delta_first = '0;
        r.delta_second = '0;
        r.entry_index = '0;
        r.entry_value = '0;
        return r;
    endfunction

    function automatic poc_req_t pic(logic [15:0] lsb, logic [15:0] frm, bit idr, bit isref,
                                     bit mm);
        poc_req_t r;
        r = blank_req();
        r.poc_lsb = lsb;
        r.frame_number = frm;
        r.is_idr = idr;
        r.is_reference = isref;
        r.has_mmco5 = mm;
        return r;
    endfunction

    function automatic poc_req_t table_req(logic [7:0] idx, logic [31:0] v);
        poc_req_t r;
        r = blank_req();
        r.op = poc_pkg::OP_TABLE;
        r.entry_index = idx;
        r.entry_value = v;
        return r;
    endfunction

    function automatic logic [31:0] rand_delta();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom;
            default: return 32'($signed($urandom_range(40)) - 20);
        endcase
    endfunction

    // Mostly a plausible picture sequence, with some noise and table writes.
    function automatic poc_req_t rand_req();
        poc_req_t r;
        int k;
        k = $urandom_range(99);
        if (k < 8) return table_req(8'($urandom), $urandom);
        r = blank_req();
        if (k < 22)
        begin
            r.poc_lsb = 16'($urandom);
            r.frame_number = 16'($urandom);
            r.is_idr = $urandom_range(1);
            r.is_reference = $urandom_range(1);
            r.has_mmco5 = $urandom_range(1);
        end
        else
        begin
            r.is_idr = ($urandom_range(99) < 5);
            if (r.is_idr)
            begin
                next_frame = '0;
                next_lsb = '0;
            end
            else
            begin
                next_frame = next_frame + 16'($urandom_range(1));
                if ($urandom_range(9) == 0) next_lsb = next_lsb - 16'($urandom_range(12));
                else next_lsb = next_lsb + 16'(2 * $urandom_range(6));
            end
            r.poc_lsb = next_lsb;
            r.frame_number = next_frame;
            r.is_reference = ($urandom_range(99) < 75);
            r.has_mmco5 = ($urandom_range(99) < 6);
        end
        r.delta_bottom = rand_delta();
        r.delta_first = rand_delta();
        r.delta_second = rand_delta();
        r.entry_index = 8'($urandom);
        r.entry_value = $urandom;
        return r;
    endfunction

    task automatic program_regs(logic [1:0] ptype, logic [4:0] l2lsb, logic [4:0] l2frm,
                                logic [7:0] clen, logic [31:0] ecd, logic [31:0] nro,
                                logic [31:0] t2b);
        wait_drained();
        apb_write(poc_pkg::REG_POC_TYPE, {30'd0, ptype});
        apb_write(poc_pkg::REG_LOG2_LSB, {27'd0, l2lsb});
        apb_write(poc_pkg::REG_LOG2_FRAME, {27'd0, l2frm});
        apb_write(poc_pkg::REG_CYCLE_LEN, {24'd0, clen});
        apb_write(poc_pkg::REG_EXP_DELTA, ecd);
        apb_write(poc_pkg::REG_NONREF_OFS, nro);
        apb_write(poc_pkg::REG_T2B_OFS, t2b);
        // Every table entry the new cycle length can reach gets a value first.
        for (int i = 0; i < clen; i++)
            if (!sb.written[i]) send(table_req(8'(i), rand_delta()));
    endtask

    task automatic random_phase(int n);
        repeat (n) send(rand_req());
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        quiet = 1'b0;
        items_sent = 0;
        next_frame = '0;
        next_lsb = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: method 0 from reset, missing reference first.
        send(pic(16'd3, 16'd1, 0, 1, 0));
        send(pic(16'hffff, 16'hffff, 1, 1, 0));
        send(pic(16'd2, 16'd0, 0, 1, 0));
        send(pic(16'd14, 16'd1, 0, 0, 0));
        send(pic(16'd12, 16'd2, 0, 1, 1));
        send(pic(16'd4, 16'd3, 0, 1, 0));
        send(table_req(8'd255, 32'h8000_0000));
        send(table_req(8'd0, 32'h7fff_ffff));

        // Unsupported method, then method 1 with an empty cycle.
        program_regs(poc_pkg::POC_TYPE_3, 5'd0, 5'd31, 8'd0, 32'd0, 32'd0, 32'd0);
        send(pic(16'd0, 16'd0, 1, 1, 0));
        program_regs(poc_pkg::POC_TYPE_1, 5'd4, 5'd4, 8'd0, 32'd5, 32'hffff_fffe, 32'd1);
        send(pic(16'd0, 16'd5, 0, 1, 0));
        send(pic(16'd0, 16'd0, 1, 0, 0));
        send(pic(16'd0, 16'd3, 0, 0, 1));

        // Method 2 with frame wrap and non-reference pictures.
        program_regs(poc_pkg::POC_TYPE_2, 5'd31, 5'd0, 8'd0, 32'd0, 32'd0, 32'd0);
        send(pic(16'd0, 16'd9, 1, 1, 0));
        send(pic(16'd0, 16'd15, 0, 0, 0));
        send(pic(16'd0, 16'd2, 0, 1, 0));
        send(pic(16'd0, 16'hffff, 0, 1, 1));

        program_regs(poc_pkg::POC_TYPE_0, 5'd4, 5'd4, 8'd0, 32'd0, 32'd0, 32'd0);
        random_phase(20);
        program_regs(poc_pkg::POC_TYPE_0, 5'd16, 5'd16, 8'd0, 32'd0, 32'd0, 32'd0);
        quiet = 1'b1;
        random_phase(30);
        quiet = 1'b0;

        // Hold the sender until the decoder has returned everything.
        wait_drained();
        program_regs(poc_pkg::POC_TYPE_1, 5'd4, 5'd4, 8'd3, $urandom, $urandom, $urandom);
        random_phase(20);
        program_regs(poc_pkg::POC_TYPE_1, 5'd0, 5'd31, 8'd0, 32'd7, 32'd3, 32'hffff_ffff);
        random_phase(15);
        program_regs(poc_pkg::POC_TYPE_1, 5'd8, 5'd8, 8'd255, 32'h8000_0000, 32'h7fff_ffff,
                     32'h8000_0000);
        random_phase(20);
        program_regs(poc_pkg::POC_TYPE_2, 5'd31, 5'd0, 8'd0, 32'd0, 32'd0, 32'd0);
        random_phase(15);
        program_regs(poc_pkg::POC_TYPE_3, 5'd10, 5'd10, 8'd1, 32'd0, 32'd0, 32'd0);
        random_phase(10);
        program_regs(poc_pkg::POC_TYPE_1, 5'd16, 5'd16, 8'd7, 32'h7fff_ffff, 32'h8000_0000,
                     32'h7fff_ffff);
        random_phase(15);
        program_regs(poc_pkg::POC_TYPE_0, 5'd5, 5'd10, 8'd0, 32'd0, 32'd0, 32'd0);
        random_phase(15);

        wait_drained();
        repeat (20) @(posedge clk);
        $display("Covered %0d requests (%0d table writes) across methods 0-3 and log2 extremes.",
                 items_sent, sb.table_writes);
        $display("Results: %0d ok, %0d missing predecessor, %0d unsupported type; %0d mismatches.",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.errors);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
